FILE: rtl/core/base64_stream_encoder_core_defines.svh
// assertion macros shared by the base64 encoder core
// no dependencies; included by the modules that carry checks
`ifndef BASE64_STREAM_ENCODER_CORE_DEFINES_SVH
`define BASE64_STREAM_ENCODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define B64E_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("b64e check failed");
`define B64E_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("b64e forbidden condition");
`else
`define B64E_ASSERT(lbl, clk, rst, prop)
`define B64E_NEVER(lbl, clk, rst, cond)
`endif

`endif

FILE: rtl/core/b64e_pkg.sv
// shared types, constants and the alphabet lookup for the base64 encoder core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] PAD_CHAR  = 8'h3D;
  localparam logic [7:0] CHR_UP_A  = 8'h41;
  localparam logic [7:0] CHR_LO_A  = 8'h61;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_SLASH = 8'h2F;

  // one input byte's worth of characters, handed from front to back
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            last;
  } job_t;

  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = CHR_UP_A + {2'b00, v};
    end else if (v < 6'd52) begin
      r = CHR_LO_A + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      r = CHR_ZERO + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      r = CHR_PLUS;
    end else begin
      r = CHR_SLASH;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/b64e_front.sv
// front end: accepts input bytes, tracks group phase and carry bits,
// and builds the character list for each byte; uses b64e_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_data,
  input  wire logic          q_full,
  output logic               q_push,
  output b64e_pkg::job_t     q_job
);
  import b64e_pkg::*;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic [3:0] carry, carry_next;
  job_t       job;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_job    = job;

  always_comb begin
    job.chars    = {PAD_CHAR, PAD_CHAR, PAD_CHAR, PAD_CHAR};
    job.last     = end_of_data;
    job.last_idx = 2'd0;
    phase_next   = phase;
    carry_next   = carry;
    unique case (phase)
      PH_SECOND: begin
        job.chars[0] = b64_sym({carry[1:0], data_byte[7:4]});
        job.chars[1] = b64_sym({data_byte[3:0], 2'b00});
        job.last_idx = end_of_data ? 2'd2 : 2'd0;
        phase_next   = PH_THIRD;
        carry_next   = data_byte[3:0];
      end
      PH_THIRD: begin
        job.chars[0] = b64_sym({carry, data_byte[7:6]});
        job.chars[1] = b64_sym(data_byte[5:0]);
        job.last_idx = 2'd1;
        phase_next   = PH_FIRST;
        carry_next   = 4'd0;
      end
      default: begin
        // the first phase, or an out-of-range one, starts a group
        job.chars[0] = b64_sym(data_byte[7:2]);
        job.chars[1] = b64_sym({data_byte[1:0], 4'b0000});
        job.last_idx = end_of_data ? 2'd3 : 2'd0;
        phase_next   = PH_SECOND;
        carry_next   = {2'b00, data_byte[1:0]};
      end
    endcase
    if (end_of_data) begin
      phase_next = PH_FIRST;
      carry_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
      carry <= 4'd0;
    end else if (q_push) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/b64e_queue.sv
// short job queue between front and back ends
// uses b64e_pkg and the assertion macros header
`timescale 1ns / 1ps
`default_nettype none
`include "base64_stream_encoder_core_defines.svh"

module b64e_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire b64e_pkg::job_t wr_job,
  output logic               full,
  input  wire logic          pop,
  output b64e_pkg::job_t     rd_job,
  output logic               empty
);
  import b64e_pkg::*;

  job_t                mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full   = (count == QCNT_W'(QDEPTH));
  assign empty  = (count == '0);
  assign rd_job = mem[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `B64E_NEVER(a_push_full, clk, rst, push && full)
  `B64E_NEVER(a_pop_empty, clk, rst, pop && empty)
  `B64E_ASSERT(a_count_range, clk, rst, count <= QCNT_W'(QDEPTH))

endmodule

`default_nettype wire

FILE: rtl/core/b64e_back.sv
// back end: walks the head job's characters, one per cycle unless stalled,
// into the output register; uses b64e_pkg and the assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "base64_stream_encoder_core_defines.svh"

module b64e_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire b64e_pkg::job_t rd_job,
  input  wire logic          rd_empty,
  output logic               rd_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_char,
  output logic               final_char
);
  import b64e_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       job_done;

  // output register may be refilled when empty or when its beat leaves
  assign load     = !out_valid || !out_stall;
  assign job_done = (idx == rd_job.last_idx);
  assign rd_pop   = load && !rd_empty && job_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= !rd_empty;
      if (!rd_empty) begin
        idx <= job_done ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !rd_empty) begin
      out_char   <= rd_job.chars[idx];
      final_char <= rd_job.last && job_done;
    end
  end

  `B64E_ASSERT(a_pop_at_end, clk, rst, rd_pop |-> (idx == rd_job.last_idx))
  `B64E_ASSERT(a_mid_job_head, clk, rst, (idx != 2'd0) |-> !rd_empty)
  `B64E_ASSERT(a_idx_bound, clk, rst, !rd_empty |-> (idx <= rd_job.last_idx))

endmodule

`default_nettype wire

FILE: rtl/core/base64_stream_encoder_core.sv
// Streaming base64 encoder (standard alphabet, '=' padding).
// Input channel: in_valid / in_stall carry one raw byte (data_byte) per beat,
// end_of_data marks the last byte of a message.
// Output channel: out_valid / out_stall carry one ASCII character (out_char)
// per beat; final_char is set on the last character of a message.
// Each byte gives one character, the third byte of a group gives two, and a
// last byte adds the flushed partial character and '=' padding (up to four).
// The first character of a byte is written into the job queue and then
// loaded into the output register, when the receiver is not stalling.
// The output register emits one character per cycle while the receiver
// does not stall; the front takes a byte every cycle while the two-entry
// job queue has room.
// Reset clears group phase, carry bits, the queue and the output valid;
// there is no clearing pass. A stalled receiver holds the output register,
// the queue fills, and then in_stall rises.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            final_char
);
  import b64e_pkg::*;

  job_t wr_job, rd_job;
  logic q_push, q_full, q_pop, q_empty;

  b64e_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .end_of_data (end_of_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (wr_job)
  );

  b64e_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rd_job     (rd_job),
    .rd_empty   (q_empty),
    .rd_pop     (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .final_char (final_char)
  );

endmodule

`default_nettype wire

FILE: test/base64_stream_encoder_core_test.sv
// self-checking testbench for the base64 stream encoder core: directed table, then random messages
// predicts characters with its own encoder model; depends on b64e_pkg and base64_stream_encoder_core
`timescale 1ns / 1ps

module base64_stream_encoder_core_test;
  import b64e_pkg::PAD_CHAR;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_BYTES = 130;
  localparam int unsigned HOLD_AFTER_BYTES = 50;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int DIRECTED_ROWS = 25;
  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } enc_char_t;

  // n_chars = 0: expected characters come from the encoder model
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [2:0]  n_chars;
    logic [31:0] chars;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_data = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       final_char;

  // encoder model state
  logic [1:0] grp_pos = 2'd0;
  logic [3:0] carry_low = 4'd0;

  enc_char_t   pending_chars[$];
  int unsigned mismatches = 0;
  int unsigned bytes_taken = 0;
  int unsigned cycle_count = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h00, 1'b1, 3'd4, "AA=="},
    '{8'hFF, 1'b1, 3'd4, "/w=="},
    '{8'hFF, 1'b0, 3'd1, "/"},
    '{8'hFF, 1'b0, 3'd1, "/"},
    '{8'hFF, 1'b1, 3'd2, "//"},
    '{8'h00, 1'b0, 3'd1, "A"},
    '{8'h00, 1'b0, 3'd1, "A"},
    '{8'h00, 1'b1, 3'd2, "AA"},
    '{8'h00, 1'b0, 3'd0, 32'h0},
    '{8'hFF, 1'b1, 3'd0, 32'h0},
    '{8'hFF, 1'b0, 3'd0, 32'h0},
    '{8'h00, 1'b1, 3'd0, 32'h0},
    '{8'h4D, 1'b0, 3'd0, 32'h0},
    '{8'h61, 1'b0, 3'd0, 32'h0},
    '{8'h6E, 1'b1, 3'd0, 32'h0},
    '{8'h4D, 1'b0, 3'd0, 32'h0},
    '{8'h61, 1'b1, 3'd0, 32'h0},
    '{8'h4D, 1'b1, 3'd0, 32'h0},
    '{8'h01, 1'b0, 3'd0, 32'h0},
    '{8'h23, 1'b0, 3'd0, 32'h0},
    '{8'h45, 1'b0, 3'd0, 32'h0},
    '{8'h67, 1'b0, 3'd0, 32'h0},
    '{8'h89, 1'b1, 3'd0, 32'h0},
    '{8'hAA, 1'b0, 3'd0, 32'h0},
    '{8'h55, 1'b1, 3'd0, 32'h0}
  };

  base64_stream_encoder_core uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .end_of_data(end_of_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .final_char (final_char)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    return B64_ALPHABET[8*(63 - v) +: 8];
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // advances the model by one byte, chars[k] holds the k-th character
  function automatic int unsigned encode_byte(input logic [7:0] b, input logic last,
                                              output logic [3:0][7:0] chars);
    int unsigned n;
    chars = {4{PAD_CHAR}};
    case (grp_pos)
      2'd1: begin
        chars[0] = sextet_char({carry_low[1:0], b[7:4]});
        n = 1;
        if (last) begin
          chars[1] = sextet_char({b[3:0], 2'b00});
          n = 3;
        end
        grp_pos = 2'd2;
        carry_low = b[3:0];
      end
      2'd2: begin
        chars[0] = sextet_char({carry_low, b[7:6]});
        chars[1] = sextet_char(b[5:0]);
        n = 2;
        grp_pos = 2'd0;
        carry_low = 4'd0;
      end
      default: begin
        // phase 3 never arises; it starts a group like phase 0
        chars[0] = sextet_char(b[7:2]);
        n = 1;
        if (last) begin
          chars[1] = sextet_char({b[1:0], 4'b0000});
          n = 4;
        end
        grp_pos = 2'd1;
        carry_low = {2'b00, b[1:0]};
      end
    endcase
    if (last) begin
      grp_pos = 2'd0;
      carry_low = 4'd0;
    end
    return n;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input int unsigned gap,
                           input logic [2:0] n_typed, input logic [31:0] typed);
    logic [3:0][7:0] model_chars;
    int unsigned     n;
    enc_char_t       c;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_data <= last;
    do @(posedge clk); while (in_stall);
    bytes_taken++;
    n = encode_byte(b, last, model_chars);
    if (n_typed != 0) n = n_typed;
    for (int unsigned k = 0; k < n; k++) begin
      c.ch = (n_typed != 0) ? typed[8*(n - 1 - k) +: 8] : model_chars[k];
      c.fin = last && (k == n - 1);
      pending_chars.push_back(c);
    end
  endtask

  // receiver: random stalls, quiet stretches, one long hold to back up the input
  always @(posedge clk) begin : rx_side
    enc_char_t   want;
    int unsigned r;
    static int unsigned stall_left = 0;
    static int unsigned quiet_left = 0;
    static int unsigned hold_left = 0;
    static bit          hold_done = 1'b0;

    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected beat: out_char %h final_char %b", out_char, final_char);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, out_char);
          mismatches++;
        end
        if (final_char !== want.fin) begin
          $error("final_char: expected %b, got %b", want.fin, final_char);
          mismatches++;
        end
      end
    end

    if (!hold_done && bytes_taken >= HOLD_AFTER_BYTES) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (quiet_left > 0) begin
      quiet_left--;
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 15);
      if (r == 0) begin
        quiet_left = $urandom_range(20, 60);
        out_stall <= 1'b0;
      end else if (r < 10) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    bit          burst;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].last, pick_gap(),
                directed_rows[i].n_chars, directed_rows[i].chars);

    // random messages, mostly short, a few long
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      r = $urandom_range(0, 9);
      if (r < 7) len = $urandom_range(1, 6);
      else if (r < 9) len = $urandom_range(7, 12);
      else len = $urandom_range(13, 30);
      burst = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < len; i++)
        send_byte(8'($urandom_range(0, 255)), i == len - 1, burst ? 0 : pick_gap(),
                  3'd0, 32'h0);
      sent += len;
    end
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
